// ===== rtl/pctp_pkg.sv =====
// Shared types, codes and constants of the pairwise collision time predictor.
// No dependencies; used by pctp_sqcmp and the top level.
package pctp_pkg;

    localparam int WIDTH_BITS = 23;                         // particle width, Q11.12
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 23'd4096;   // 1.0

    localparam int TIME_BITS = 24;                          // time, unsigned Q12.12

    // common width for magnitude clamps and time saturation (widest |dx| is 33 bits)
    localparam int CL_W = 34;
    localparam logic [CL_W-1:0] TIME_MAX  = 34'h0_00FF_FFFF;
    localparam logic [CL_W-1:0] CLAMP_MAX = 34'h0_7FFF_FFFF;

    localparam int SUM_W = 64;                              // squared-distance sums

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic REG_WIDTH_IDX = 1'b0;                  // paddr[2] of particle_width

    localparam int OUT_W = 32;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NONE  = 2'd0;
    localparam t_kind KIND_HORIZ = 2'd1;
    localparam t_kind KIND_VERT  = 2'd2;
    localparam t_kind KIND_SIDE  = 2'd3;

    typedef struct packed {
        logic same_id;      // equal indices
        logic h_oppose;     // x velocities nonzero and opposite
        logic v_oppose;     // y velocities nonzero and opposite
        logic side;         // a crossing pair of velocity components
        logic h_toward;     // dx * u1 > 0
        logic v_toward;     // dy * v1 > 0
    } t_pair_flags;

    function automatic logic [TIME_BITS-1:0] sat_time(input logic [CL_W-1:0] v);
        return (v > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : v[TIME_BITS-1:0];
    endfunction

endpackage

// ===== rtl/pctp_sqcmp.sv =====
// Registered squares of the present and future gaps, and the closer-than compare.
// Depends on pctp_pkg.
module pctp_sqcmp #(
    parameter int SQ_W = 25
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [SQ_W-1:0]                  i_dxc,
    input  logic [SQ_W-1:0]                  i_dyc,
    input  logic [pctp_pkg::WIDTH_BITS-1:0]  i_fxs,
    input  logic [pctp_pkg::WIDTH_BITS-1:0]  i_fys,
    output logic                             o_closer
);
    import pctp_pkg::*;

    logic [2*SQ_W-1:0]       r_dx2;
    logic [2*SQ_W-1:0]       r_dy2;
    logic [2*WIDTH_BITS-1:0] r_fx2;
    logic [2*WIDTH_BITS-1:0] r_fy2;
    logic [SUM_W-1:0]        w_now;
    logic [SUM_W-1:0]        w_future;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx2 <= i_dxc * i_dxc;
            r_dy2 <= i_dyc * i_dyc;
            r_fx2 <= i_fxs * i_fxs;
            r_fy2 <= i_fys * i_fys;
        end
    end

    // future gaps are below the width here, so their squares need no clamp
    assign w_now    = SUM_W'(r_dx2) + SUM_W'(r_dy2);
    assign w_future = SUM_W'(r_fx2) + SUM_W'(r_fy2);
    assign o_closer = w_future < w_now;

endmodule

// ===== rtl/pairwise_collision_time_predictor_unit.sv =====
// Top level of the pairwise collision time predictor: APB register, stream ports
// and a six-stage pipeline. Depends on pctp_pkg and pctp_sqcmp.
//
// Usage
//   Slave stream (i_s_*): one word per particle pair, accepted when i_s_tvalid and
//   o_s_tready are both high. Master stream (o_m_*): one result word per pair,
//   in order, taken when o_m_tvalid and i_m_tready are both high.
//   APB port: one register, particle_width (23 bits, unsigned Q11.12) at byte
//   address 0; pready is tied high, reads return the register. Write it only
//   while the pipeline is empty.
//   A pair passes through six register stages, the first loaded when the pair is
//   accepted; the last is the output register that drives o_m_tdata.
//   Throughput: one pair per cycle unless stalled; no loop or shared unit limits it.
//   Stall: each stage holds while the stage after it is full and held, so a
//   stalled receiver fills the bubbles first and then drops o_s_tready; nothing
//   is lost or repeated.
//   Reset (i_rst_n low, synchronous): all stages empty, particle_width = 1.0.
//
// Stages
//   1 gaps dx, dy; index compare   2 magnitudes, direction tests
//   3 future gaps fx, fy, width compares, clamps   4 |fx|, |fy|, ||dx|-|dy||
//   5 squares (pctp_sqcmp) and head-on decision   6 side test, output register
module pairwise_collision_time_predictor_unit #(
    parameter int POSITION_BITS = 24,
    parameter int INDEX_BITS    = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata, low bit up: first_index, first_x, first_y, first_u, first_v,
    // second_index, second_x, second_y, second_u, second_v, zero fill
    input  logic [((2*(INDEX_BITS+2*POSITION_BITS+4)+7)/8)*8-1:0] i_s_tdata,
    // master stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata, low bit up: will_collide, collision_kind[1:0],
    // time_to_collision[23:0], zero fill
    output logic [pctp_pkg::OUT_W-1:0]           o_m_tdata,
    // APB register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pctp_pkg::APB_AW-1:0]          paddr,
    input  logic [pctp_pkg::APB_DW-1:0]          pwdata,
    output logic [pctp_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import pctp_pkg::*;

    localparam int P      = POSITION_BITS;
    localparam int HALF   = INDEX_BITS + 2*P + 4;
    localparam int OFF_I1 = 0;
    localparam int OFF_X1 = INDEX_BITS;
    localparam int OFF_Y1 = INDEX_BITS + P;
    localparam int OFF_U1 = INDEX_BITS + 2*P;
    localparam int OFF_V1 = OFF_U1 + 2;
    localparam int OFF_I2 = HALF;
    localparam int OFF_X2 = HALF + OFF_X1;
    localparam int OFF_Y2 = HALF + OFF_Y1;
    localparam int OFF_U2 = HALF + OFF_U1;
    localparam int OFF_V2 = HALF + OFF_V1;

    localparam int DW   = P + 1;                    // signed gap
    localparam int MW   = P + 1;                    // gap magnitude
    localparam int XW   = MW + 1;                   // |dx| - |dy|, signed
    localparam int FW   = P + 3;                    // future gap, signed
    localparam int LT_W = ((FW > WIDTH_BITS) ? FW : WIDTH_BITS) + 1;
    localparam int SQ_W = (MW > 31) ? 31 : MW;      // clamped magnitude
    localparam int NSTG = 6;

    function automatic logic signed [2:0] unit_val(input logic [1:0] c);
        return (c == 2'b00) ? 3'sd0 : (c[1] ? 3'sb111 : 3'sd1);
    endfunction

    // ---------------- configuration register ----------------
    logic [WIDTH_BITS-1:0] r_width;
    logic                  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_WIDTH_IDX);
    assign prdata   = (paddr[2] == REG_WIDTH_IDX) ? APB_DW'(r_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (w_cfg_wr) begin
            r_width <= pwdata[WIDTH_BITS-1:0];
        end
    end

    // ---------------- stage handshake ----------------
    // a stage loads when it is empty or when the stage after it moves on
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] | i_m_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] | w_en[k+1];
        end
    end

    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- stage 1: gaps ----------------
    logic signed [DW-1:0] r_s1_dx, r_s1_dy;
    logic                 r_s1_same;
    logic [1:0]           r_s1_u1, r_s1_v1, r_s1_u2, r_s1_v2;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_dx   <= DW'($signed(i_s_tdata[OFF_X2 +: P])) -
                         DW'($signed(i_s_tdata[OFF_X1 +: P]));
            r_s1_dy   <= DW'($signed(i_s_tdata[OFF_Y2 +: P])) -
                         DW'($signed(i_s_tdata[OFF_Y1 +: P]));
            r_s1_same <= i_s_tdata[OFF_I1 +: INDEX_BITS] == i_s_tdata[OFF_I2 +: INDEX_BITS];
            r_s1_u1   <= i_s_tdata[OFF_U1 +: 2];
            r_s1_v1   <= i_s_tdata[OFF_V1 +: 2];
            r_s1_u2   <= i_s_tdata[OFF_U2 +: 2];
            r_s1_v2   <= i_s_tdata[OFF_V2 +: 2];
        end
    end

    // ---------------- stage 2: magnitudes, direction ----------------
    // velocity code 10 counts as -1: only the sign bit and "nonzero" matter
    t_pair_flags          n_s2_flags, r_s2_flags;
    logic [MW-1:0]        n_s2_adx, n_s2_ady, r_s2_adx, r_s2_ady;
    logic signed [2:0]    n_s2_kx, n_s2_ky, r_s2_kx, r_s2_ky;
    logic signed [DW-1:0] r_s2_dx, r_s2_dy;
    logic                 w_u1nz, w_v1nz, w_u2nz, w_v2nz;

    always_comb begin
        w_u1nz = r_s1_u1 != 2'b00;
        w_v1nz = r_s1_v1 != 2'b00;
        w_u2nz = r_s1_u2 != 2'b00;
        w_v2nz = r_s1_v2 != 2'b00;
        n_s2_adx = r_s1_dx[DW-1] ? MW'(-r_s1_dx) : MW'(r_s1_dx);
        n_s2_ady = r_s1_dy[DW-1] ? MW'(-r_s1_dy) : MW'(r_s1_dy);
        n_s2_flags.same_id  = r_s1_same;
        n_s2_flags.h_oppose = w_u1nz & w_u2nz & (r_s1_u1[1] ^ r_s1_u2[1]);
        n_s2_flags.v_oppose = w_v1nz & w_v2nz & (r_s1_v1[1] ^ r_s1_v2[1]);
        n_s2_flags.side     = (w_u1nz & w_v2nz) | (w_v1nz & w_u2nz);
        n_s2_flags.h_toward = w_u1nz & (r_s1_dx != '0) & (r_s1_dx[DW-1] == r_s1_u1[1]);
        n_s2_flags.v_toward = w_v1nz & (r_s1_dy != '0) & (r_s1_dy[DW-1] == r_s1_v1[1]);
        n_s2_kx = unit_val(r_s1_u2) - unit_val(r_s1_u1);
        n_s2_ky = unit_val(r_s1_v2) - unit_val(r_s1_v1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_flags <= n_s2_flags;
            r_s2_adx   <= n_s2_adx;
            r_s2_ady   <= n_s2_ady;
            r_s2_kx    <= n_s2_kx;
            r_s2_ky    <= n_s2_ky;
            r_s2_dx    <= r_s1_dx;
            r_s2_dy    <= r_s1_dy;
        end
    end

    // ---------------- stage 3: future gaps, width compares ----------------
    // dt = |dx|; fx = dx + (u2-u1)*dt with u2-u1 in -2..2
    logic signed [FW-1:0] w_ax1, w_ax2, n_s3_fx, n_s3_fy, r_s3_fx, r_s3_fy;
    logic signed [XW-1:0] r_s3_diff;
    logic [CL_W-1:0]      w_adx_e, w_ady_e;
    logic [SQ_W-1:0]      r_s3_dxc, r_s3_dyc;
    logic [MW-1:0]        r_s3_adx, r_s3_ady;
    logic                 r_s3_adx_lt, r_s3_ady_lt;
    t_pair_flags          r_s3_flags;

    always_comb begin
        w_ax1 = $signed(FW'(r_s2_adx));
        w_ax2 = w_ax1 <<< 1;
        case (r_s2_kx)
            3'b001:  n_s3_fx = FW'(r_s2_dx) + w_ax1;
            3'b010:  n_s3_fx = FW'(r_s2_dx) + w_ax2;
            3'b111:  n_s3_fx = FW'(r_s2_dx) - w_ax1;
            3'b110:  n_s3_fx = FW'(r_s2_dx) - w_ax2;
            default: n_s3_fx = FW'(r_s2_dx);
        endcase
        case (r_s2_ky)
            3'b001:  n_s3_fy = FW'(r_s2_dy) + w_ax1;
            3'b010:  n_s3_fy = FW'(r_s2_dy) + w_ax2;
            3'b111:  n_s3_fy = FW'(r_s2_dy) - w_ax1;
            3'b110:  n_s3_fy = FW'(r_s2_dy) - w_ax2;
            default: n_s3_fy = FW'(r_s2_dy);
        endcase
        w_adx_e = CL_W'(r_s2_adx);
        w_ady_e = CL_W'(r_s2_ady);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_fx     <= n_s3_fx;
            r_s3_fy     <= n_s3_fy;
            r_s3_diff   <= $signed(XW'(r_s2_adx)) - $signed(XW'(r_s2_ady));
            r_s3_adx_lt <= LT_W'(r_s2_adx) < LT_W'(r_width);
            r_s3_ady_lt <= LT_W'(r_s2_ady) < LT_W'(r_width);
            r_s3_dxc    <= (w_adx_e > CLAMP_MAX) ? SQ_W'(CLAMP_MAX) : SQ_W'(w_adx_e);
            r_s3_dyc    <= (w_ady_e > CLAMP_MAX) ? SQ_W'(CLAMP_MAX) : SQ_W'(w_ady_e);
            r_s3_adx    <= r_s2_adx;
            r_s3_ady    <= r_s2_ady;
            r_s3_flags  <= r_s2_flags;
        end
    end

    // ---------------- stage 4: magnitudes of future gaps ----------------
    logic [FW-1:0]         w_fxm, w_fym;
    logic [XW-1:0]         w_dm;
    logic [LT_W-1:0]       w_fxe, w_fye, w_eps;
    logic [WIDTH_BITS-1:0] r_s4_fxs, r_s4_fys;
    logic [SQ_W-1:0]       r_s4_dxc, r_s4_dyc;
    logic                  r_s4_fx_lt, r_s4_fy_lt, r_s4_d_lt, r_s4_adx_lt, r_s4_ady_lt;
    logic [TIME_BITS-1:0]  r_s4_th, r_s4_tv, r_s4_ts;
    t_pair_flags           r_s4_flags;

    always_comb begin
        w_fxm = r_s3_fx[FW-1] ? FW'(-r_s3_fx) : FW'(r_s3_fx);
        w_fym = r_s3_fy[FW-1] ? FW'(-r_s3_fy) : FW'(r_s3_fy);
        w_dm  = r_s3_diff[XW-1] ? XW'(-r_s3_diff) : XW'(r_s3_diff);
        w_fxe = LT_W'(w_fxm);
        w_fye = LT_W'(w_fym);
        w_eps = LT_W'(r_width);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_fx_lt  <= w_fxe < w_eps;
            r_s4_fy_lt  <= w_fye < w_eps;
            r_s4_d_lt   <= LT_W'(w_dm) < w_eps;
            r_s4_fxs    <= w_fxe[WIDTH_BITS-1:0];
            r_s4_fys    <= w_fye[WIDTH_BITS-1:0];
            r_s4_dxc    <= r_s3_dxc;
            r_s4_dyc    <= r_s3_dyc;
            r_s4_adx_lt <= r_s3_adx_lt;
            r_s4_ady_lt <= r_s3_ady_lt;
            r_s4_th     <= sat_time(CL_W'(r_s3_adx >> 1));
            r_s4_tv     <= sat_time(CL_W'(r_s3_ady >> 1));
            r_s4_ts     <= sat_time(CL_W'(r_s3_adx));
            r_s4_flags  <= r_s3_flags;
        end
    end

    // ---------------- stage 5: squares and head-on decision ----------------
    logic                 w_closer;
    logic                 n_s5_hit, n_s5_side;
    t_kind                n_s5_kind;
    logic [TIME_BITS-1:0] n_s5_time;
    logic                 r_s5_hit, r_s5_side;
    t_kind                r_s5_kind;
    logic [TIME_BITS-1:0] r_s5_time, r_s5_ts;

    pctp_sqcmp #(
        .SQ_W (SQ_W)
    ) u_sqcmp (
        .i_clk    (i_clk),
        .i_en     (w_en[4]),
        .i_dxc    (r_s4_dxc),
        .i_dyc    (r_s4_dyc),
        .i_fxs    (r_s4_fxs),
        .i_fys    (r_s4_fys),
        .o_closer (w_closer)
    );

    // first test that applies decides; a head-on pair moving apart ends as none
    always_comb begin
        n_s5_hit  = 1'b0;
        n_s5_kind = KIND_NONE;
        n_s5_time = '0;
        n_s5_side = 1'b0;
        if (r_s4_flags.same_id) begin
            n_s5_hit = 1'b0;
        end else if (r_s4_ady_lt && r_s4_flags.h_oppose) begin
            if (r_s4_flags.h_toward) begin
                n_s5_hit  = 1'b1;
                n_s5_kind = KIND_HORIZ;
                n_s5_time = r_s4_th;
            end
        end else if (r_s4_adx_lt && r_s4_flags.v_oppose) begin
            if (r_s4_flags.v_toward) begin
                n_s5_hit  = 1'b1;
                n_s5_kind = KIND_VERT;
                n_s5_time = r_s4_tv;
            end
        end else begin
            n_s5_side = r_s4_flags.side & r_s4_d_lt & r_s4_fx_lt & r_s4_fy_lt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_hit  <= n_s5_hit;
            r_s5_kind <= n_s5_kind;
            r_s5_time <= n_s5_time;
            r_s5_side <= n_s5_side;
            r_s5_ts   <= r_s4_ts;
        end
    end

    // ---------------- stage 6: side-to-side result, output register ----------------
    logic                 r_s6_hit;
    t_kind                r_s6_kind;
    logic [TIME_BITS-1:0] r_s6_time;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            if (r_s5_side && w_closer) begin
                r_s6_hit  <= 1'b1;
                r_s6_kind <= KIND_SIDE;
                r_s6_time <= r_s5_ts;
            end else begin
                r_s6_hit  <= r_s5_hit;
                r_s6_kind <= r_s5_kind;
                r_s6_time <= r_s5_time;
            end
        end
    end

    assign o_m_tdata = {(OUT_W-TIME_BITS-3)'(0), r_s6_time, r_s6_kind, r_s6_hit};

endmodule
